// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: src/ekdbw_pkg.sv
package ekdbw_pkg;

	localparam int KEY_COUNT = 25;
	localparam int LINE_W = KEY_COUNT + 2;
	localparam int ENC_A = KEY_COUNT;
	localparam int ENC_B = KEY_COUNT + 1;
	localparam int WINDOW_TICKS_DEF = 5;
	localparam int LIMIT_W = 10;
	localparam int COUNT_W = 11;
	localparam int WHEEL_W = 8;

	localparam logic [LIMIT_W-1:0] RESEND_LIMIT_RST = LIMIT_W'(100);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic signed [WHEEL_W:0] WHEEL_MAX = 9'sd127;
	localparam logic signed [WHEEL_W:0] WHEEL_MIN = -9'sd127;

	typedef logic [LINE_W-1:0] line_t;
	typedef logic signed [WHEEL_W-1:0] wheel_t;

	typedef enum logic [2:0] {
		EVT_A_RISE = 3'd0,
		EVT_A_FALL = 3'd1,
		EVT_B_RISE = 3'd2,
		EVT_B_FALL = 3'd3,
		EVT_NONE   = 3'd7
	} enc_evt_t;

	function automatic wheel_t sat_wheel(input logic signed [WHEEL_W:0] v);
		wheel_t r;
		if (v > WHEEL_MAX) begin
			r = WHEEL_MAX[WHEEL_W-1:0];
		end else if (v < WHEEL_MIN) begin
			r = WHEEL_MIN[WHEEL_W-1:0];
		end else begin
			r = v[WHEEL_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: src/eager_key_debouncer_with_wheel_core.sv
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// input   | in_valid, in_stall, raw_inputs, tx_failed | request in
// output  | out_valid, out_stall, key_state,          | request out
//         | send_report, wheel_amount, idle           |
// config  | wr_en, wr_data (resend limit)             | write only
//
// one request per cycle sustained while the result is not stalled; a request passes
// an input register, then the result register, with the whole tick evaluated in between.
// reset clears the change ring, all tick state and loads the resend limit of 100.
// a stalled result holds; the input register still takes a request while the
// result register is free or being drained in the same cycle.
module eager_key_debouncer_with_wheel_core #(
	parameter int WINDOW_TICKS = ekdbw_pkg::WINDOW_TICKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [ekdbw_pkg::LIMIT_W-1:0]  wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ekdbw_pkg::LINE_W-1:0]   raw_inputs,
	input  logic                           tx_failed,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ekdbw_pkg::LINE_W-1:0]   key_state,
	output logic                           send_report,
	output logic signed [ekdbw_pkg::WHEEL_W-1:0] wheel_amount,
	output logic                           idle
);
	import ekdbw_pkg::*;

	localparam int SLOT_W = (WINDOW_TICKS > 1) ? $clog2(WINDOW_TICKS) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_TICKS - 1);

	// input stage
	logic  in_vld_s1;
	line_t raw_s1;
	logic  fail_s1;

	// result stage
	logic   out_vld_s2;
	line_t  key_state_s2;
	logic   send_s2;
	wheel_t amount_s2;
	logic   idle_s2;

	// tick state
	line_t              hist_q [WINDOW_TICKS];
	logic [SLOT_W-1:0]  slot_q;
	line_t              prev_raw_q;
	line_t              settled_q;
	logic [COUNT_W-1:0] count_q;
	wheel_t             pending_q;
	wheel_t             last_sent_q;
	enc_evt_t           last_evt_q;
	logic [LIMIT_W-1:0] limit_q;

	logic advance;

	// next-state values
	line_t              recent;
	line_t              next_settled;
	logic [SLOT_W-1:0]  next_slot;
	logic               enc_moved;
	enc_evt_t           evt;
	logic signed [1:0]  step;
	wheel_t             pending_trk;
	wheel_t             report_amt;
	logic               do_send;
	logic               do_idle;
	logic [COUNT_W-1:0] next_count;

	assign advance  = in_vld_s1 && (!out_vld_s2 || !out_stall);
	assign in_stall = in_vld_s1 && !advance;

	assign out_valid    = out_vld_s2;
	assign key_state    = key_state_s2;
	assign send_report  = send_s2;
	assign wheel_amount = amount_s2;
	assign idle         = idle_s2;

	always_comb begin
		recent = '0;
		for (int i = 0; i < WINDOW_TICKS; i++) begin
			recent = recent | hist_q[i];
		end
	end

	always_comb begin
		logic a0, a1, b0, b1;
		logic unchanged;
		logic signed [WHEEL_W:0] sum_pend;
		logic signed [WHEEL_W:0] sum_rep;
		wheel_t base;

		next_slot = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;

		// keys outside the window follow raw at once, encoder lines pass raw
		next_settled = ((raw_s1 ^ settled_q) & ~recent) ^ settled_q;
		next_settled[ENC_A] = raw_s1[ENC_A];
		next_settled[ENC_B] = raw_s1[ENC_B];

		a0 = settled_q[ENC_A];
		b0 = settled_q[ENC_B];
		a1 = raw_s1[ENC_A];
		b1 = raw_s1[ENC_B];
		enc_moved = (a0 != a1) || (b0 != b1);

		// a change on both lines counts as line a
		if (a0 == a1) begin
			evt = b1 ? EVT_B_RISE : EVT_B_FALL;
		end else begin
			evt = a1 ? EVT_A_RISE : EVT_A_FALL;
		end

		step = 2'sd0;
		if (last_evt_q == EVT_A_RISE && evt == EVT_B_RISE) begin
			step = 2'sd1;
		end else if (last_evt_q == EVT_A_RISE && evt == EVT_B_FALL) begin
			step = -2'sd1;
		end else if (last_evt_q == EVT_B_RISE && evt == EVT_A_RISE) begin
			step = -2'sd1;
		end else if (last_evt_q == EVT_B_RISE && evt == EVT_A_FALL) begin
			step = 2'sd1;
		end
		if (a1 && b1) begin
			step = 2'sd0;
		end

		sum_pend = {pending_q[WHEEL_W-1], pending_q} + {{(WHEEL_W-1){step[1]}}, step};
		pending_trk = enc_moved ? sat_wheel(sum_pend) : pending_q;

		unchanged = (settled_q == next_settled);
		do_idle   = unchanged && (recent == '0);
		do_send   = do_idle || !unchanged || (count_q > COUNT_W'(limit_q));

		base = fail_s1 ? last_sent_q : '0;
		sum_rep = {base[WHEEL_W-1], base} + {pending_trk[WHEEL_W-1], pending_trk};
		report_amt = sat_wheel(sum_rep);

		if (do_send) begin
			next_count = '0;
		end else if (count_q != COUNT_MAX) begin
			next_count = count_q + 1'b1;
		end else begin
			next_count = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= RESEND_LIMIT_RST;
		end else if (wr_en) begin
			limit_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			in_vld_s1 <= 1'b1;
		end else if (advance) begin
			in_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			raw_s1  <= raw_inputs;
			fail_s1 <= tx_failed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_TICKS; i++) begin
				hist_q[i] <= '0;
			end
			slot_q      <= '0;
			prev_raw_q  <= '0;
			settled_q   <= '0;
			count_q     <= '0;
			pending_q   <= '0;
			last_sent_q <= '0;
			last_evt_q  <= EVT_NONE;
		end else if (advance) begin
			hist_q[next_slot] <= raw_s1 ^ prev_raw_q;
			slot_q     <= next_slot;
			prev_raw_q <= raw_s1;
			settled_q  <= next_settled;
			count_q    <= next_count;
			if (enc_moved) begin
				last_evt_q <= evt;
			end
			if (do_send) begin
				pending_q   <= '0;
				last_sent_q <= report_amt;
			end else begin
				pending_q <= pending_trk;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s2 <= 1'b0;
		end else if (advance) begin
			out_vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_state_s2 <= next_settled;
			send_s2      <= do_send;
			amount_s2    <= do_send ? report_amt : '0;
			idle_s2      <= do_idle;
		end
	end

endmodule

// File: src/ekdbw_checker.sv
`include "assert_macros.svh"

module ekdbw_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [ekdbw_pkg::LINE_W-1:0]   key_state,
	input logic                           send_report,
	input logic signed [ekdbw_pkg::WHEEL_W-1:0] wheel_amount,
	input logic                           idle
);
	import ekdbw_pkg::*;

	logic [LINE_W+WHEEL_W+1:0] out_bundle;
	assign out_bundle = {key_state, send_report, wheel_amount, idle};

	// a held result keeps its payload
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_bundle))

	// the input side only stalls behind a blocked result
	`ASSERT_IMPLY(a_in_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// going idle always comes with a report
	`ASSERT_IMPLY(a_idle_sends, clk, arst_n, out_valid && idle, send_report)

	// no wheel movement leaves without a report
	`ASSERT_IMPLY(a_no_report_no_wheel, clk, arst_n, out_valid && !send_report, wheel_amount == '0)

	// wheel amount stays within the symmetric range
	`ASSERT_IMPLY(a_wheel_range, clk, arst_n, out_valid, wheel_amount != 8'h80)

endmodule

bind eager_key_debouncer_with_wheel_core ekdbw_checker u_ekdbw_checker (.*);

// File: sim/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ekdbw_pkg::*;

	localparam int RING_DEPTH = WINDOW_TICKS_DEF;
	localparam int WHEEL_LIM = 127;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SAT_STEPS = 135;

	typedef struct packed {
		line_t  keys;
		logic   send;
		wheel_t amount;
		logic   idle;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [LIMIT_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	line_t raw_inputs = '0;
	logic tx_failed = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	line_t key_state;
	logic send_report;
	wheel_t wheel_amount;
	logic idle;

	eager_key_debouncer_with_wheel_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_inputs(raw_inputs),
		.tx_failed(tx_failed),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_state(key_state),
		.send_report(send_report),
		.wheel_amount(wheel_amount),
		.idle(idle)
	);

	always #1 clk = ~clk;

	// debouncer state as the block should hold it
	line_t change_ring [RING_DEPTH];
	int ring_slot;
	line_t last_raw;
	line_t held_keys;
	logic [COUNT_W-1:0] resend_ticks;
	logic [LIMIT_W-1:0] resend_lim;
	int wheel_pend;
	int wheel_sent;
	enc_evt_t last_edge_evt;

	tick_result_t expected_ticks [$];
	int mismatches = 0;
	int cycle_count = 0;
	int sent_count = 0;
	line_t cur_raw = '0;
	bit gaps_on = 1'b1;
	int rx_hold_cycles = 0;

	function automatic int clip_wheel(int v);
		if (v > WHEEL_LIM) begin
			return WHEEL_LIM;
		end
		if (v < -WHEEL_LIM) begin
			return -WHEEL_LIM;
		end
		return v;
	endfunction

	function automatic void follow_encoder(line_t was, line_t now);
		enc_evt_t evt;
		int step;
		if (was[ENC_A] == now[ENC_A] && was[ENC_B] == now[ENC_B]) begin
			return;
		end
		// both lines moving counts as a move of line a
		if (was[ENC_A] == now[ENC_A]) begin
			evt = now[ENC_B] ? EVT_B_RISE : EVT_B_FALL;
		end else begin
			evt = now[ENC_A] ? EVT_A_RISE : EVT_A_FALL;
		end
		step = 0;
		if (last_edge_evt == EVT_A_RISE && evt == EVT_B_RISE) begin
			step = 1;
		end else if (last_edge_evt == EVT_A_RISE && evt == EVT_B_FALL) begin
			step = -1;
		end else if (last_edge_evt == EVT_B_RISE && evt == EVT_A_RISE) begin
			step = -1;
		end else if (last_edge_evt == EVT_B_RISE && evt == EVT_A_FALL) begin
			step = 1;
		end
		if (now[ENC_A] && now[ENC_B]) begin
			step = 0;
		end
		wheel_pend = clip_wheel(wheel_pend + step);
		last_edge_evt = evt;
	endfunction

	function automatic tick_result_t debounce_tick(line_t raw, logic failed);
		line_t recent;
		line_t next_keys;
		line_t enc_mask;
		tick_result_t r;
		recent = '0;
		foreach (change_ring[i]) begin
			recent |= change_ring[i];
		end
		ring_slot = (ring_slot + 1) % RING_DEPTH;
		change_ring[ring_slot] = raw ^ last_raw;
		last_raw = raw;

		enc_mask = '0;
		enc_mask[ENC_A] = 1'b1;
		enc_mask[ENC_B] = 1'b1;
		// keys that moved inside the window keep their old level
		next_keys = ((raw ^ held_keys) & ~recent) ^ held_keys;
		next_keys = (next_keys & ~enc_mask) | (raw & enc_mask);
		follow_encoder(held_keys, next_keys);

		r.idle = (held_keys == next_keys) && (recent == '0);
		r.send = r.idle || (held_keys != next_keys) || (resend_ticks > resend_lim);
		held_keys = next_keys;
		r.amount = '0;
		if (r.send) begin
			if (!failed) begin
				wheel_sent = 0;
			end
			wheel_sent = clip_wheel(wheel_sent + wheel_pend);
			wheel_pend = 0;
			r.amount = wheel_t'(wheel_sent);
			resend_ticks = '0;
		end else if (resend_ticks != COUNT_MAX) begin
			resend_ticks = resend_ticks + 1'b1;
		end
		r.keys = held_keys;
		return r;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_ticks.size());
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin : result_check
		tick_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ticks.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual keys %h send %b",
					$time, key_state, send_report);
				mismatches++;
			end else begin
				want = expected_ticks.pop_front();
				if (key_state !== want.keys) begin
					$display("%0t: key_state expected %h actual %h", $time, want.keys, key_state);
					mismatches++;
				end
				if (send_report !== want.send) begin
					$display("%0t: send_report expected %b actual %b", $time, want.send,
						send_report);
					mismatches++;
				end
				if (wheel_amount !== want.amount) begin
					$display("%0t: wheel_amount expected %0d actual %0d", $time, want.amount,
						wheel_amount);
					mismatches++;
				end
				if (idle !== want.idle) begin
					$display("%0t: idle expected %b actual %b", $time, want.idle, idle);
					mismatches++;
				end
			end
		end
	end

	// result side stall: random bursts, or one long hold-off when asked
	initial begin : result_stall_gen
		int n;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				n = rx_hold_cycles;
				rx_hold_cycles = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_req(line_t raw, logic failed);
		in_valid <= 1'b1;
		raw_inputs <= raw;
		tx_failed <= failed;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_ticks.push_back(debounce_tick(raw, failed));
		cur_raw = raw;
		sent_count++;
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_resend_limit(logic [LIMIT_W-1:0] v);
		wait_drained();
		wr_en <= 1'b1;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		resend_lim = v;
	endtask

	// key toggled every tick: after its first change it stays inside the window, so only a timeout reports
	task automatic bounce_key(int key, int ticks);
		line_t raw;
		repeat (ticks) begin
			raw = cur_raw;
			raw[key] = ~raw[key];
			send_req(raw, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic hold_keys(int ticks);
		line_t raw;
		raw = cur_raw;
		repeat ($urandom_range(1, 3)) begin
			raw[$urandom_range(0, KEY_COUNT - 1)] ^= 1'b1;
		end
		repeat (ticks) send_req(raw, 1'($urandom_range(0, 1)));
	endtask

	// three ticks per detent; forward moves +1, backward -1
	task automatic spin_wheel(bit forward, int steps, bit always_failed);
		logic [1:0] fwd_seq [3] = '{2'b01, 2'b11, 2'b10};
		logic [1:0] back_seq [3] = '{2'b10, 2'b11, 2'b01};
		line_t raw;
		for (int i = 0; i < steps * 3; i++) begin
			raw = cur_raw;
			{raw[ENC_B], raw[ENC_A]} = forward ? fwd_seq[i % 3] : back_seq[i % 3];
			if ($urandom_range(0, 7) == 0) begin
				raw[$urandom_range(0, KEY_COUNT - 1)] ^= 1'b1;
			end
			send_req(raw, always_failed ? 1'b1 : 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic random_session(int n_items);
		int stop_at;
		stop_at = sent_count + n_items;
		while (sent_count < stop_at) begin
			case ($urandom_range(0, 4))
				0: begin
					repeat ($urandom_range(1, 6)) begin
						send_req(line_t'($urandom), 1'($urandom_range(0, 1)));
					end
				end
				1: hold_keys($urandom_range(1, 12));
				2: bounce_key($urandom_range(0, KEY_COUNT - 1), $urandom_range(2, 15));
				default: spin_wheel(1'($urandom_range(0, 1)), $urandom_range(1, 12), 1'b0);
			endcase
		end
	endtask

	task automatic test_directed();
		line_t dir_raw [25] = '{
			27'h0000000, 27'h7FFFFFF, 27'h7FFFFFF, 27'h0000000, 27'h0000000,
			27'h0000000, 27'h0000000, 27'h0000000, 27'h0000000, 27'h0000000,
			27'h0000001, 27'h1000001, 27'h3000001, 27'h7000001, 27'h5000001,
			27'h3000001, 27'h7000001, 27'h5000001, 27'h3000001, 27'h5000001,
			27'h7000001, 27'h3000001, 27'h5000001, 27'h0000000, 27'h0000000
		};
		logic dir_fail [25] = '{
			1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
			1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
			1'b1, 1'b1, 1'b0, 1'b0, 1'b1
		};
		for (int i = 0; i < 25; i++) begin
			send_req(dir_raw[i], dir_fail[i]);
		end
	endtask

	task automatic test_resend_timeout();
		write_resend_limit('0);
		bounce_key(0, 12);
		write_resend_limit(LIMIT_W'(7));
		bounce_key(KEY_COUNT - 1, 30);
		write_resend_limit(RESEND_LIMIT_RST);
		bounce_key(12, 110);
		write_resend_limit('1);
		bounce_key(3, 40);
	endtask

	task automatic test_wheel_saturation();
		spin_wheel(1'b1, SAT_STEPS, 1'b1);
		// a good transmit drops the carried amount
		send_req(cur_raw, 1'b0);
		spin_wheel(1'b0, SAT_STEPS, 1'b1);
		send_req(cur_raw, 1'b0);
	endtask

	task automatic test_random_mix();
		write_resend_limit(LIMIT_W'(3));
		random_session(100);
		write_resend_limit(LIMIT_W'($urandom_range(1, 60)));
		random_session(100);
		write_resend_limit('1);
		random_session(40);
	endtask

	task automatic test_backpressure();
		wait_drained();
		gaps_on = 1'b0;
		rx_hold_cycles = 150;
		repeat (40) send_req(line_t'($urandom), 1'($urandom_range(0, 1)));
		wait_drained();
		gaps_on = 1'b1;
	endtask

	task automatic test_quiet_tail();
		write_resend_limit(LIMIT_W'($urandom_range(0, 20)));
		gaps_on = 1'b0;
		random_session(100);
	endtask

	initial begin
		foreach (change_ring[i]) begin
			change_ring[i] = '0;
		end
		ring_slot = 0;
		last_raw = '0;
		held_keys = '0;
		resend_ticks = '0;
		resend_lim = RESEND_LIMIT_RST;
		wheel_pend = 0;
		wheel_sent = 0;
		last_edge_evt = EVT_NONE;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_resend_timeout();
		test_wheel_saturation();
		test_random_mix();
		test_backpressure();
		test_quiet_tail();

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
